### hw/rtl/sdq_pkg.sv
// ----------------------------------------------------------------------------
// sdq_pkg
// Shared types and constants of the sorted double-ended queue.
// ----------------------------------------------------------------------------
package sdq_pkg;

  // Number of cells in the sorted chain.
  localparam int unsigned Capacity = 16;
  // Width of one held value.
  localparam int unsigned ValW     = 32;
  // Width of the held count, wide enough to hold Capacity itself.
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  // Width of a cell index.
  localparam int unsigned IdxW     = $clog2(Capacity);
  // Width of the count field on the result channel.
  localparam int unsigned CountW   = 5;

  typedef logic signed [ValW-1:0] slot_t;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_POP_MIN = 2'd1,
    ACT_POP_MAX = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic  ins;
    logic  pop_min;
    slot_t value;
  } sdq_cmd_t;

endpackage

### hw/rtl/sdq_req_if.sv
// ----------------------------------------------------------------------------
// sdq_req_if
// Request channel: one operation and its operand per beat.
// ----------------------------------------------------------------------------
interface sdq_req_if import sdq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        action;
  logic signed [31:0] value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

### hw/rtl/sdq_rsp_if.sv
// ----------------------------------------------------------------------------
// sdq_rsp_if
// Response channel: status and queue summary, one beat per request.
// ----------------------------------------------------------------------------
interface sdq_rsp_if import sdq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [CountW-1:0]   count;
  logic signed [31:0]  smallest;
  logic signed [31:0]  largest;
  logic                empty_res;

  modport source (output valid, output status, output count, output smallest,
                  output largest, output empty_res, input ready);
  modport sink   (input valid, input status, input count, input smallest,
                  input largest, input empty_res, output ready);
endinterface

### hw/rtl/sdq_cell.sv
// ----------------------------------------------------------------------------
// sdq_cell
// One slot of the sorted chain: compares, shifts up on insert, down on pop-min.
// ----------------------------------------------------------------------------
module sdq_cell import sdq_pkg::*; (
  input  logic     clk_i,
  input  logic     occupied_i,
  input  sdq_cmd_t cmd_i,
  input  slot_t    left_value_i,
  input  logic     left_after_i,
  input  slot_t    right_value_i,
  output logic     after_o,
  output slot_t    value_o,
  output slot_t    value_d_o
);

  slot_t value_q;
  slot_t value_d;

  // The new value lands at or below this cell unless the cell holds a value
  // no greater than it; equal values stay in front of the new one.
  assign after_o = !(occupied_i && (value_q <= cmd_i.value));

  always_comb begin
    value_d = value_q;
    priority if (cmd_i.ins) begin
      if (after_o) begin
        value_d = left_after_i ? left_value_i : cmd_i.value;
      end
    end else if (cmd_i.pop_min) begin
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o   = value_q;
  assign value_d_o = value_d;

endmodule

### hw/rtl/sorted_double_ended_queue.sv
// ----------------------------------------------------------------------------
// sorted_double_ended_queue
// Bounded sorted multiset of signed values with insert, pop-min and pop-max.
// ----------------------------------------------------------------------------
// The queue holds up to Capacity signed 32-bit values in ascending order in a
// chain of cells, one value per cell, with the smallest in cell 0. Every
// request beat yields exactly one response beat. An insert is broadcast to all
// cells at once: each cell compares its value with the new one, the cells
// holding larger values move up one place and the new value drops into the
// gap, behind any equal values. A pop of the smallest shifts the whole chain
// down by one; a pop of the largest only shortens the count. An insert into a
// full queue and a pop from an empty one leave the contents alone and are
// flagged in the status; an unused action code does nothing and reports done.
// Each request is handled in the cycle of acceptance: the chain compare and
// shift settle then, and the response is presented from an output register
// on the following cycle. The request side stays ready while that register
// is empty or is being drained, so a new beat can be taken every cycle as
// long as responses are consumed. The store starts empty after reset.
// ----------------------------------------------------------------------------
module sorted_double_ended_queue import sdq_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  sdq_req_if.sink      req_i,
  sdq_rsp_if.source    rsp_o
);

  // Number of values held; cells at or above it contain stale data.
  logic [CntW-1:0] held_q;
  logic [CntW-1:0] held_d;

  logic            accept;
  logic            full;
  logic            empty;
  logic            do_ins;
  logic            do_pop_min;
  logic            do_pop_max;
  status_e         status;
  sdq_cmd_t        cmd;

  slot_t           cell_val   [Capacity];
  slot_t           cell_val_d [Capacity];
  logic            cell_after [Capacity];
  logic            cell_occ   [Capacity];

  logic [CntW-1:0] last_idx;

  // Output register of the response channel.
  logic            rsp_valid_q;
  logic [1:0]      rsp_status_q;
  logic [CountW-1:0] rsp_count_q;
  slot_t           rsp_smallest_q;
  slot_t           rsp_largest_q;
  logic            rsp_empty_q;

  // A new request is taken whenever the response register is free or is
  // handing its beat over in this cycle.
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign full  = (held_q == CntW'(Capacity));
  assign empty = (held_q == '0);

  always_comb begin
    do_ins     = 1'b0;
    do_pop_min = 1'b0;
    do_pop_max = 1'b0;
    status     = ST_DONE;
    unique case (action_e'(req_i.action))
      ACT_INSERT: begin
        if (full) begin
          status = ST_FULL;
        end else begin
          do_ins = accept;
        end
      end
      ACT_POP_MIN: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          do_pop_min = accept;
        end
      end
      ACT_POP_MAX: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          do_pop_max = accept;
        end
      end
      default: begin
        status = ST_DONE;
      end
    endcase
  end

  always_comb begin
    held_d = held_q;
    priority if (do_ins) begin
      held_d = held_q + CntW'(1);
    end else if (do_pop_min || do_pop_max) begin
      held_d = held_q - CntW'(1);
    end
  end

  assign cmd.ins     = do_ins;
  assign cmd.pop_min = do_pop_min;
  assign cmd.value   = req_i.value;

  // The chain: each cell sees its left neighbor for inserts and its right
  // neighbor for pops of the smallest value.
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    slot_t left_value;
    logic  left_after;
    slot_t right_value;

    assign cell_occ[i] = (CntW'(i) < held_q);

    if (i == 0) begin : g_first
      assign left_value = '0;
      assign left_after = 1'b0;
    end else begin : g_inner
      assign left_value = cell_val[i-1];
      assign left_after = cell_after[i-1];
    end

    if (i == Capacity - 1) begin : g_last
      assign right_value = cell_val[i];
    end else begin : g_body
      assign right_value = cell_val[i+1];
    end

    sdq_cell u_cell (
      .clk_i        (clk_i),
      .occupied_i   (cell_occ[i]),
      .cmd_i        (cmd),
      .left_value_i (left_value),
      .left_after_i (left_after),
      .right_value_i(right_value),
      .after_o      (cell_after[i]),
      .value_o      (cell_val[i]),
      .value_d_o    (cell_val_d[i])
    );
  end

  // Index of the top held value after this request; only used when non-empty.
  assign last_idx = held_d - CntW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      held_q <= held_d;
      if (accept) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_status_q   <= status;
      rsp_count_q    <= CountW'(held_d);
      rsp_empty_q    <= (held_d == '0);
      rsp_smallest_q <= (held_d == '0) ? '0 : cell_val_d[0];
      rsp_largest_q  <= (held_d == '0) ? '0 : cell_val_d[last_idx[IdxW-1:0]];
    end
  end

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = rsp_status_q;
  assign rsp_o.count     = rsp_count_q;
  assign rsp_o.smallest  = rsp_smallest_q;
  assign rsp_o.largest   = rsp_largest_q;
  assign rsp_o.empty_res = rsp_empty_q;

endmodule

### hw/rtl/sdq_checker.sv
// ----------------------------------------------------------------------------
// sdq_checker
// Port-level checks of the sorted double-ended queue response channel.
// ----------------------------------------------------------------------------
module sdq_checker import sdq_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input logic [1:0]        rsp_status_i,
  input logic [CountW-1:0] rsp_count_i,
  input logic signed [31:0] rsp_smallest_i,
  input logic signed [31:0] rsp_largest_i,
  input logic              rsp_empty_i
);

  // A stalled response beat stays valid and keeps its count and extreme values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_count_i)
      && $stable(rsp_smallest_i) && $stable(rsp_largest_i))
    else $error("response payload changed while stalled");

  // The empty flag agrees with the count, and an empty queue reports zeros.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_empty_i == (rsp_count_i == '0))
      && (!rsp_empty_i || (rsp_smallest_i == 0 && rsp_largest_i == 0)))
    else $error("empty flag inconsistent with count or values");

  // The held values stay ordered and within capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_count_i <= CountW'(Capacity)
      && (rsp_empty_i || rsp_smallest_i <= rsp_largest_i))
    else $error("count beyond capacity or smallest above largest");

  // A full-drop leaves a full queue, and an empty-removal an empty one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_status_i != ST_FULL || rsp_count_i == CountW'(Capacity))
      && (rsp_status_i != ST_EMPTY || rsp_empty_i))
    else $error("status inconsistent with count");

endmodule

bind sorted_double_ended_queue sdq_checker u_sdq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_status_i  (rsp_o.status),
  .rsp_count_i   (rsp_o.count),
  .rsp_smallest_i(rsp_o.smallest),
  .rsp_largest_i (rsp_o.largest),
  .rsp_empty_i   (rsp_o.empty_res)
);

### test/sorted_double_ended_queue_tb.sv
// ----------------------------------------------------------------------------
// sorted_double_ended_queue_tb
// Self-checking testbench for the sorted double-ended queue.
// ----------------------------------------------------------------------------
// A clocked driver sends insert, pop-min, pop-max and no-op beats from a list
// of pending items. The list starts with a short directed run: the empty and
// full corners, the value extremes and the unused action code. A long random
// run follows, made of phases that lean toward inserts, removals or neither, so
// that the store swings between empty and full. Each accepted request is run
// through a sorted shadow store, and the expected summary is queued. A clocked
// monitor compares every response beat, field by field, against the oldest summary.
// Both sides idle at random, the response side holds off for a long stretch
// once, and the request side pauses twice until all responses are back.
// ----------------------------------------------------------------------------
module sorted_double_ended_queue_tb import sdq_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // The opcode that the package leaves unnamed: the block must ignore it.
  localparam logic [1:0] ActNoOp = 2'd3;

  localparam int RandomItems   = 1400;
  // Beats in this window run with no idling on either side.
  localparam int SteadyFrom    = 900;
  localparam int SteadyTo      = 1200;
  // The response side stops taking beats for a while after this many requests.
  localparam int HoldAfter     = 300;
  localparam int HoldCycles    = 80;
  // Cycles without any beat on either channel before the run gives up.
  localparam int WatchdogLimit = 2000;
  // Ample slack at the end of the run, after the last response has come back.
  localparam int TailCycles    = 10;

  // One pending request. A set drain bit makes the driver wait until every
  // response owed so far has come back before it offers this item.
  typedef struct {
    logic [1:0] action;
    slot_t      value;
    bit         drain;
  } req_item_t;

  // What one response beat must carry.
  typedef struct {
    status_e           status;
    logic [CountW-1:0] count;
    slot_t             smallest;
    slot_t             largest;
    logic              is_empty;
  } summary_t;

  logic clk_i;
  logic rst_ni;

  sdq_req_if req_if ();
  sdq_rsp_if rsp_if ();

  sorted_double_ended_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  req_item_t item_queue[$];
  summary_t  summary_due[$];
  // Shadow copy of the store contents, kept in ascending order.
  slot_t     sorted_vals[$];

  int   beats_in;
  int   beats_out;
  int   errors;
  logic hold_off;

  always begin
    #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Shadow store. Applies one request and returns the summary that the block
  // must report for it. An insert goes behind all equal values, a full store
  // drops the insert, an empty store ignores a pop and the spare code does
  // nothing at all.
  // --------------------------------------------------------------------------
  function automatic summary_t predict_summary(logic [1:0] act, slot_t val);
    summary_t s;
    int       pos;
    s.status = ST_DONE;
    case (act)
      ACT_INSERT: begin
        if (sorted_vals.size() >= Capacity) begin
          s.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < sorted_vals.size() && sorted_vals[pos] <= val) pos++;
          sorted_vals.insert(pos, val);
        end
      end
      ACT_POP_MIN: begin
        if (sorted_vals.size() == 0) s.status = ST_EMPTY;
        else void'(sorted_vals.pop_front());
      end
      ACT_POP_MAX: begin
        if (sorted_vals.size() == 0) s.status = ST_EMPTY;
        else void'(sorted_vals.pop_back());
      end
      default: ;
    endcase
    s.count    = CountW'(sorted_vals.size());
    s.is_empty = (sorted_vals.size() == 0);
    s.smallest = s.is_empty ? '0 : sorted_vals[0];
    s.largest  = s.is_empty ? '0 : sorted_vals[sorted_vals.size() - 1];
    return s;
  endfunction

  // Random idling with a chance of about nine in a hundred, except in the steady
  // window, where both sides run flat out.
  function automatic bit idle_now(int beats);
    if (beats >= SteadyFrom && beats < SteadyTo) return 1'b0;
    return $urandom_range(99) < 9;
  endfunction

  function automatic slot_t pick_value();
    case ($urandom_range(3))
      // A narrow range, so that equal values pile up in the store.
      0:       return slot_t'($signed($urandom_range(16)) - 8);
      1: begin
        case ($urandom_range(3))
          0:       return 32'sh7fff_ffff;
          1:       return 32'sh8000_0000;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return slot_t'($urandom);
    endcase
  endfunction

  task automatic add_item(logic [1:0] act, slot_t val, bit drain = 1'b0);
    req_item_t it;
    it.action = act;
    it.value  = val;
    it.drain  = drain;
    item_queue.push_back(it);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at response %0d, %s: got %h, expected %h",
             beats_out, what, got, want);
    errors++;
  endtask

  // --------------------------------------------------------------------------
  // Request driver. On a beat it runs the shadow store and queues the summary,
  // then it offers the next pending item unless it idles or has to wait for
  // the response side to drain. A held beat keeps its payload untouched.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_req
    req_item_t nxt;
    logic      busy;
    logic      send;
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
    end else begin
      busy = req_if.valid;
      if (req_if.valid && req_if.ready) begin
        summary_due.push_back(predict_summary(req_if.action, req_if.value));
        beats_in <= beats_in + 1;
        busy = 1'b0;
      end
      if (!busy) begin
        send = 1'b0;
        if (item_queue.size() != 0) begin
          nxt  = item_queue[0];
          send = !(nxt.drain && summary_due.size() != 0) && !idle_now(beats_in);
        end
        if (send) begin
          void'(item_queue.pop_front());
          req_if.valid  <= 1'b1;
          req_if.action <= nxt.action;
          req_if.value  <= nxt.value;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Response ready: random idling, plus the long hold-off below.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= !hold_off && !idle_now(beats_in);
    end
  end

  // Once enough traffic has gone through, the response side stops taking
  // beats. The request side keeps offering, so the output register fills
  // and the block has to stall its input until the hold-off ends.
  initial begin
    while (beats_in < HoldAfter) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Response monitor: every beat must match the oldest queued summary.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_rsp
    summary_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (summary_due.size() == 0) begin
        report_mismatch("beat with no request behind it", 32'(rsp_if.count), '0);
      end else begin
        want = summary_due.pop_front();
        if (rsp_if.status !== want.status)
          report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
        if (rsp_if.count !== want.count)
          report_mismatch("count", 32'(rsp_if.count), 32'(want.count));
        if (rsp_if.smallest !== want.smallest)
          report_mismatch("smallest", rsp_if.smallest, want.smallest);
        if (rsp_if.largest !== want.largest)
          report_mismatch("largest", rsp_if.largest, want.largest);
        if (rsp_if.empty_res !== want.is_empty)
          report_mismatch("empty_res", 32'(rsp_if.empty_res), 32'(want.is_empty));
      end
      beats_out <= beats_out + 1;
    end
  end

  // Watchdog: gives up when neither channel has moved for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus, reset and end of run.
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int         r;
    int         lean;
    logic [1:0] act;

    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    hold_off      = 1'b0;
    beats_in      = 0;
    beats_out     = 0;
    errors        = 0;
    req_if.valid  = 1'b0;
    req_if.action = ACT_INSERT;
    req_if.value  = '0;
    rsp_if.ready  = 1'b0;

    // Removals and the spare code on an empty store.
    add_item(ACT_POP_MIN, 32'sd77);
    add_item(ACT_POP_MAX, -32'sd77);
    add_item(ActNoOp, 32'sd1);
    // Extremes of the value range, then fill up with duplicates mixed in.
    add_item(ACT_INSERT, 32'sh7fff_ffff);
    add_item(ACT_INSERT, 32'sh8000_0000);
    add_item(ACT_INSERT, 32'sd0);
    add_item(ACT_INSERT, -32'sd1);
    add_item(ACT_INSERT, 32'sd5);
    add_item(ACT_INSERT, 32'sd5);
    add_item(ACT_INSERT, -32'sd5);
    add_item(ACT_INSERT, 32'sh7fff_ffff);
    add_item(ACT_INSERT, 32'sh8000_0000);
    add_item(ACT_INSERT, 32'sd0);
    add_item(ACT_INSERT, 32'sd1);
    add_item(ACT_INSERT, 32'sd2);
    add_item(ACT_INSERT, -32'sd2);
    add_item(ACT_INSERT, 32'sd100);
    add_item(ACT_INSERT, -32'sd100);
    add_item(ACT_INSERT, 32'sd5);
    // The store is full now: this insert must be dropped.
    add_item(ACT_INSERT, 32'sd3);
    add_item(ActNoOp, -32'sd3);
    add_item(ACT_POP_MIN, 32'sd0);
    add_item(ACT_POP_MAX, 32'sd0);

    // Random part in phases of a hundred items that lean toward inserts,
    // toward removals, or neither, so that the store keeps reaching both
    // the full and the empty corner.
    for (int n = 0; n < RandomItems; n++) begin
      case ((n / 100) % 4)
        0, 3:    lean = 75;
        1:       lean = 30;
        default: lean = 52;
      endcase
      r = $urandom_range(99);
      if (r < 3) act = ActNoOp;
      else if (r < lean) act = ACT_INSERT;
      else if ($urandom_range(1) == 0) act = ACT_POP_MIN;
      else act = ACT_POP_MAX;
      add_item(act, pick_value(), n == 0 || n == 700);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (item_queue.size() != 0 || req_if.valid) @(posedge clk_i);
    while (summary_due.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
